// ----- src/dfu_pkg.sv -----
package dfu_pkg;

   localparam int DFU_QUEUE_DEPTH = 4;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
   localparam logic [6:0] LEN_EXT64     = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_EMPTY   = 2'd1;
   localparam logic [1:0] EV_BADOP   = 2'd2;
   localparam logic [1:0] EV_TRUNC   = 2'd3;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_SKIP    = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [1:0] event_res;
      logic [3:0] frame_opcode_out;
      logic       frame_fin_out;
      logic       last_of_frame;
   } rsp_type;

   // one classified result waiting for the back end
   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic [1:0] event_res;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ----- src/websocket_frame_deframer_unmask.sv -----
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_data   (rx_byte, rx_last)
// rsp      out  rsp_valid/rsp_ready    rsp_data   (payload_byte, event_res, opcode, fin, last)
//
// One byte accepted per clock while the queue has room; results are queued, then registered.
// The header parser retires a byte every cycle; the result queue
// (QUEUE_DEPTH entries) absorbs rsp stalls, req_ready drops only when it is full.
// Synchronous active-high reset returns the parser to the first header byte
// and empties the queue and output register.
module websocket_frame_deframer_unmask
   import dfu_pkg::*;
#(
   parameter int QUEUE_DEPTH = DFU_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         push;
   entry_type    push_data;
   logic         pop;
   entry_type    head;

   dfu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   dfu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   dfu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/dfu_front.sv -----
module dfu_front
   import dfu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_data
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        long_ff, long_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic        masked_ff, masked_in;

   logic       accept;
   logic [7:0] b;
   logic [3:0] cnt_inc;
   logic       op_ok;
   logic       short_len;
   logic       ext_done;
   logic       mask_done;
   logic       rem_one;
   logic       ext_zero;
   logic [7:0] key_sel;
   logic       open_frame;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.rx_byte;
   assign cnt_inc   = cnt_ff + 4'd1;
   assign op_ok     = (b[3:0] == OP_TEXT) || (b[3:0] == OP_BINARY) || (b[3:0] == OP_CLOSE);
   assign short_len = b[6:0] <= LEN_MAX_SHORT;
   assign ext_done  = cnt_inc == (long_ff ? EXT64_BYTES : EXT16_BYTES);
   assign mask_done = cnt_inc >= KEY_BYTES;
   assign rem_one   = rem_ff == 64'd1;
   assign ext_zero  = {rem_ff[55:0], b} == 64'd0;

   always_comb begin
      unique case (idx_ff)
         2'd0: key_sel = key_ff[31:24];
         2'd1: key_sel = key_ff[23:16];
         2'd2: key_sel = key_ff[15:8];
         2'd3: key_sel = key_ff[7:0];
         default: key_sel = key_ff[7:0];
      endcase
   end

   // next parse phase before rx_last is applied
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HDR0: begin
            phase_in = op_ok ? PH_HDR1 : PH_SKIP;
         end
         PH_HDR1: begin
            if (!short_len) begin
               phase_in = PH_EXTLEN;
            end else if (b[7]) begin
               phase_in = PH_MASK;
            end else begin
               phase_in = (b[6:0] == 7'd0) ? PH_DONE : PH_PAYLOAD;
            end
         end
         PH_EXTLEN: begin
            if (ext_done) begin
               if (masked_ff) begin
                  phase_in = PH_MASK;
               end else begin
                  phase_in = ext_zero ? PH_DONE : PH_PAYLOAD;
               end
            end
         end
         PH_MASK: begin
            if (mask_done) begin
               phase_in = (rem_ff == 64'd0) ? PH_DONE : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (rem_one) begin
               phase_in = PH_DONE;
            end
         end
         PH_SKIP, PH_DONE: begin
            phase_in = phase_ff;
         end
         default: phase_in = phase_ff;
      endcase
   end

   // header fields, counters and the classified result
   always_comb begin
      cnt_in    = cnt_ff;
      long_in   = long_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      push      = 1'b0;
      push_data = '0;
      unique case (phase_ff)
         PH_HDR0: begin
            fin_in    = b[7];
            opcode_in = b[3:0];
            masked_in = 1'b0;
            cnt_in    = 4'd0;
            long_in   = 1'b0;
            rem_in    = 64'd0;
            key_in    = 32'd0;
            idx_in    = 2'd0;
            if (!op_ok) begin
               push                = 1'b1;
               push_data.event_res = EV_BADOP;
            end
         end
         PH_HDR1: begin
            masked_in = b[7];
            cnt_in    = 4'd0;
            if (short_len) begin
               rem_in = {57'd0, b[6:0]};
               if (!b[7]) begin
                  idx_in = 2'd0;
                  if (b[6:0] == 7'd0) begin
                     push                = 1'b1;
                     push_data.event_res = EV_EMPTY;
                  end
               end
            end else begin
               long_in = b[6:0] == LEN_EXT64;
               rem_in  = 64'd0;
            end
         end
         PH_EXTLEN: begin
            rem_in = {rem_ff[55:0], b};
            cnt_in = cnt_inc;
            if (ext_done) begin
               cnt_in = 4'd0;
               if (!masked_ff) begin
                  idx_in = 2'd0;
                  if (ext_zero) begin
                     push                = 1'b1;
                     push_data.event_res = EV_EMPTY;
                  end
               end
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], b};
            cnt_in = cnt_inc;
            if (mask_done) begin
               idx_in = 2'd0;
               if (rem_ff == 64'd0) begin
                  push                = 1'b1;
                  push_data.event_res = EV_EMPTY;
               end
            end
         end
         PH_PAYLOAD: begin
            push                = 1'b1;
            push_data.event_res = EV_PAYLOAD;
            push_data.raw_byte  = b;
            push_data.key_byte  = masked_ff ? key_sel : 8'd0;
            idx_in              = idx_ff + 2'd1;
            rem_in              = rem_ff - 64'd1;
         end
         PH_SKIP, PH_DONE: begin
            push = 1'b0;
         end
         default: push = 1'b0;
      endcase

      open_frame = (phase_in == PH_HDR1) || (phase_in == PH_EXTLEN) ||
                   (phase_in == PH_MASK) || (phase_in == PH_PAYLOAD);
      if (req_data.rx_last && open_frame) begin
         // truncation keeps the byte only when it was a payload transfer
         if (!(push && push_data.event_res == EV_PAYLOAD)) begin
            push_data.raw_byte = 8'd0;
            push_data.key_byte = 8'd0;
         end
         push                = 1'b1;
         push_data.event_res = EV_TRUNC;
      end
      push_data.opcode = opcode_in;
      push_data.fin    = fin_in;
      push_data.last   = (push_data.event_res != EV_PAYLOAD) || (phase_in == PH_DONE);
      push             = push && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         cnt_ff    <= 4'd0;
         long_ff   <= 1'b0;
         rem_ff    <= 64'd0;
         key_ff    <= 32'd0;
         idx_ff    <= 2'd0;
         opcode_ff <= 4'd0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= req_data.rx_last ? PH_HDR0 : phase_in;
         cnt_ff    <= cnt_in;
         long_ff   <= long_in;
         rem_ff    <= rem_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
      end
   end

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != 64'd0)
      else $error("payload phase with nothing remaining");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.rx_last |=> phase_ff == PH_HDR0)
      else $error("rx_last did not return parser to first header byte");

endmodule

// ----- src/dfu_queue.sv -----
module dfu_queue
   import dfu_pkg::*;
#(
   parameter int DEPTH = DFU_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_data,
   input  logic         pop,
   output entry_type    head,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("transfer into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty queue");

endmodule

// ----- src/dfu_back.sv -----
module dfu_back
   import dfu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      rsp_in.payload_byte     = head.raw_byte ^ head.key_byte;
      rsp_in.event_res        = head.event_res;
      rsp_in.frame_opcode_out = head.opcode;
      rsp_in.frame_fin_out    = head.fin;
      rsp_in.last_of_frame    = head.last;
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
